@@ rtl/core/pae_pkg.sv @@
package pae_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_SEARCH = 3'd2,
        OP_UPDATE = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_PUT,
        S_DONE
    } state_t;

endpackage

@@ rtl/core/pae_ram.sv @@
module pae_ram
    import pae_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/positional_array_engine.sv @@
// Channel   Dir  Transfer contents
// s_axis    in   tuser: operation; tdata: position, data_value, search_key
// m_axis    out  tuser: status; tdata: found_index, read_value, element_count
//
// One request at a time. Entries live in a single-port-write, registered-read
// RAM; every shift step or compare costs one RAM read, pipelined one deep.
// Update, a rejected request, a search of an empty array, delete of the last entry
// and insert at the end read no entry; read fetches one, search scans from entry 0
// until a match, delete shifts the later entries down, insert shifts them up.
// Reset clears the count and the control state; the RAM is not cleared.
// A result waiting on m_tready holds in the output register; the next
// request is still accepted and stalls only when its own result is ready.
module positional_array_engine
    import pae_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // position[4:0], data_value[36:5], search_key[68:37]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // found_index[3:0], read_value[35:4], element_count[40:36]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 5) ? CW : 5;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     end_reg, end_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     paddr_reg, paddr_next;
    status_t           status_reg, status_next;
    logic [AW-1:0]     found_reg, found_next;
    logic [DATA_W-1:0] rd_reg, rd_next;

    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [3:0]        m_found_reg, m_found_next;
    logic [DATA_W-1:0] m_rd_reg, m_rd_next;
    logic [4:0]        m_cnt_reg, m_cnt_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic [PW-1:0]     in_pos;
    logic [PW-1:0]     cnt_ext;
    op_t               in_op;
    logic              match;

    assign in_pos  = PW'(s_tdata[4:0]);
    assign cnt_ext = PW'(cnt_reg);
    assign in_op   = op_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign match   = pend_reg && (op_reg == OP_SEARCH) && (ram_rdata == key_reg);

    // Shifts read one entry while writing the one two places away, so a read
    // never meets a write to the same entry and no forwarding is needed.
    pae_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        end_reg      <= end_next;
        paddr_reg    <= paddr_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        rd_reg       <= rd_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_rd_reg     <= m_rd_next;
        m_cnt_reg    <= m_cnt_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        key_next      = key_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        end_next      = end_reg;
        pend_next     = 1'b0;
        paddr_next    = paddr_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        rd_next       = rd_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_rd_next     = m_rd_reg;
        m_cnt_next    = m_cnt_reg;
        ram_we        = 1'b0;
        ram_waddr     = paddr_reg;
        ram_wdata     = ram_rdata;
        ram_re        = 1'b0;
        ram_raddr     = idx_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        // Finish the read issued last cycle: move, compare or capture it.
        if (pend_reg && (state_reg == S_SCAN || state_reg == S_FLUSH))
        begin
            case (op_reg)
                OP_INSERT:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = paddr_reg + AW'(1);
                end
                OP_DELETE:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = paddr_reg - AW'(1);
                end
                OP_READ:
                begin
                    rd_next = ram_rdata;
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = in_op;
                    pos_next    = in_pos;
                    val_next    = s_tdata[36:5];
                    key_next    = s_tdata[68:37];
                    status_next = ST_OK;
                    found_next  = '0;
                    rd_next     = '0;
                    state_next  = S_DONE;
                    case (in_op)
                        OP_INSERT:
                        begin
                            if (in_pos > cnt_ext)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (cnt_reg == CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (in_pos == cnt_ext)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                idx_next   = AW'(cnt_reg - CW'(1));
                                end_next   = AW'(in_pos);
                                state_next = S_SCAN;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (in_pos >= cnt_ext)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (in_pos + PW'(1) == cnt_ext)
                            begin
                                cnt_next = cnt_reg - CW'(1);
                            end
                            else
                            begin
                                idx_next   = AW'(in_pos + PW'(1));
                                end_next   = AW'(cnt_reg - CW'(1));
                                state_next = S_SCAN;
                            end
                        end
                        OP_SEARCH:
                        begin
                            status_next = ST_NOTFOUND;
                            if (cnt_reg != '0)
                            begin
                                idx_next   = '0;
                                end_next   = AW'(cnt_reg - CW'(1));
                                state_next = S_SCAN;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (in_pos >= cnt_ext)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(in_pos);
                                ram_wdata = s_tdata[36:5];
                            end
                        end
                        OP_READ:
                        begin
                            if (in_pos >= cnt_ext)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                idx_next   = AW'(in_pos);
                                end_next   = AW'(in_pos);
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = ST_BADPOS;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    status_next = ST_OK;
                    found_next  = paddr_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = idx_reg;
                    if (idx_reg == end_reg)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (op_reg == OP_INSERT)
                    begin
                        idx_next = idx_reg - AW'(1);
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            S_FLUSH:
            begin
                state_next = S_DONE;
                if (match)
                begin
                    status_next = ST_OK;
                    found_next  = paddr_reg;
                end
                if (op_reg == OP_INSERT)
                begin
                    state_next = S_PUT;
                end
                if (op_reg == OP_DELETE)
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(pos_reg);
                ram_wdata  = val_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_found_next  = 4'(found_reg);
                    m_rd_next     = rd_reg;
                    m_cnt_next    = 5'(cnt_reg);
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {7'd0, m_cnt_reg, m_rd_reg, m_found_reg};

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != S_IDLE)
        else $error("accepted request did not start");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> (cnt_reg == $past(cnt_reg) + CW'(1))
            || (cnt_reg == $past(cnt_reg) - CW'(1)))
        else $error("count moved by more than one");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> CW'(ram_waddr) <= cnt_reg)
        else $error("write beyond valid entries");

    a_done_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> !ram_re && !ram_we)
        else $error("RAM access while a result is pending");

endmodule

@@ tb/positional_array_engine_test.sv @@
`timescale 1ns / 100ps

module positional_array_engine_test;
    import pae_pkg::*;

    // operation codes the block does not define; they must be rejected
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int RANDOM_ITEMS = 1530;
    localparam int BLOCK_ITEMS  = 40;
    localparam int TAIL_CYCLES  = 40;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [2:0]  op;
        logic [4:0]  pos;
        logic [31:0] value;
        logic [31:0] key;
    } array_request_t;

    typedef struct {
        logic [1:0]  status;
        logic [3:0]  index;
        logic [31:0] read_value;
        logic [4:0]  count;
    } array_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    array_request_t request_q[$];
    array_result_t  result_q[$];

    // predictor state
    logic [31:0] model_entries[DEPTH_DEF];
    int          model_count = 0;

    // generator's view of the fill level, so that most requests are in range
    int          gen_count = 0;
    logic [31:0] key_pool[$];

    int  n_accepted = 0;
    int  n_errors = 0;
    int  total_items = 0;
    int  send_idle = 25;
    int  recv_idle = 64;
    bit  rx_hold = 1'b0;
    bit  in_took = 1'b0;

    positional_array_engine u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic array_result_t apply_request(array_request_t r);
        array_result_t res;
        int            i;
        res.status     = ST_OK;
        res.index      = '0;
        res.read_value = '0;
        case (r.op)
            OP_INSERT:
            begin
                if (r.pos > model_count)
                    res.status = ST_BADPOS;
                else if (model_count >= DEPTH_DEF)
                    res.status = ST_FULL;
                else
                begin
                    for (i = model_count; i > r.pos; i--)
                        model_entries[i] = model_entries[i - 1];
                    model_entries[r.pos] = r.value;
                    model_count++;
                end
            end
            OP_DELETE:
            begin
                if (r.pos >= model_count)
                    res.status = ST_BADPOS;
                else
                begin
                    for (i = r.pos; i + 1 < model_count; i++)
                        model_entries[i] = model_entries[i + 1];
                    model_count--;
                end
            end
            OP_SEARCH:
            begin
                res.status = ST_NOTFOUND;
                for (i = 0; i < model_count; i++)
                begin
                    if (res.status == ST_NOTFOUND && model_entries[i] == r.key)
                    begin
                        res.status = ST_OK;
                        res.index  = i[3:0];
                    end
                end
            end
            OP_UPDATE:
            begin
                if (r.pos >= model_count)
                    res.status = ST_BADPOS;
                else
                    model_entries[r.pos] = r.value;
            end
            OP_READ:
            begin
                if (r.pos >= model_count)
                    res.status = ST_BADPOS;
                else
                    res.read_value = model_entries[r.pos];
            end
            default:
                res.status = ST_BADPOS;
        endcase
        res.count = model_count[4:0];
        return res;
    endfunction

    task automatic add_request(logic [2:0] op, logic [4:0] pos, logic [31:0] value,
                               logic [31:0] key);
        array_request_t r;
        r.op    = op;
        r.pos   = pos;
        r.value = value;
        r.key   = key;
        request_q.push_back(r);
        total_items++;
        if (op == OP_INSERT && pos <= gen_count && gen_count < DEPTH_DEF)
        begin
            gen_count++;
            key_pool.push_back(value);
            if (key_pool.size() > 32)
                key_pool.delete(0);
        end
        else if (op == OP_DELETE && pos < gen_count)
            gen_count--;
    endtask

    function automatic logic [31:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return $urandom();
        if (sel < 8)
            return $urandom_range(7);
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // driver: offer the head of the request queue, hold it until the transfer
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && in_took)
                request_q.delete(0);
            if (s_tvalid && !in_took)
                s_tvalid <= 1'b1;
            else if (request_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, request_q[0].key, request_q[0].value, request_q[0].pos};
                s_tuser  <= request_q[0].op;
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= !rx_hold && ($urandom_range(99) >= recv_idle);
    end

    // monitor: predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin : monitor
        array_request_t req;
        array_result_t  want;
        in_took <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            req.op    = s_tuser;
            req.pos   = s_tdata[4:0];
            req.value = s_tdata[36:5];
            req.key   = s_tdata[68:37];
            result_q.push_back(apply_request(req));
            n_accepted++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (result_q.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result, expected none, actual status %0d data %0h",
                         $time, m_tuser, m_tdata);
            end
            else
            begin
                want = result_q.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("found_index", want.index, m_tdata[3:0]);
                check_field("read_value", want.read_value, m_tdata[35:4]);
                check_field("element_count", want.count, m_tdata[40:36]);
            end
        end
    end

    // long receiver stall while the sender keeps offering
    initial
    begin
        wait (n_accepted >= 300);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : main
        int          blk;
        int          n;
        int          ins_pct;
        int unsigned pick;
        logic [2:0]  op;
        logic [4:0]  pos;
        logic [31:0] key;

        // directed: empty array, edge values, duplicates, out of range, bad codes
        add_request(OP_INSERT, 5'd1, 32'h1111_1111, 32'h0);
        add_request(OP_READ, 5'd0, 32'h0, 32'h0);
        add_request(OP_DELETE, 5'd0, 32'h0, 32'h0);
        add_request(OP_UPDATE, 5'd0, 32'h2222_2222, 32'h0);
        add_request(OP_SEARCH, 5'd0, 32'h0, 32'h0);
        add_request(OP_INSERT, 5'd0, 32'h8000_0000, 32'h0);
        add_request(OP_INSERT, 5'd1, 32'h7fff_ffff, 32'h0);
        add_request(OP_INSERT, 5'd0, 32'h0000_0000, 32'hffff_ffff);
        add_request(OP_INSERT, 5'd3, 32'hffff_ffff, 32'h0);
        add_request(OP_INSERT, 5'd5, 32'h1234_5678, 32'h0);
        add_request(OP_SEARCH, 5'd0, 32'h0, 32'h7fff_ffff);
        add_request(OP_SEARCH, 5'd31, 32'hffff_ffff, 32'h1234_5678);
        add_request(OP_UPDATE, 5'd1, 32'h7fff_ffff, 32'h0);
        add_request(OP_SEARCH, 5'd0, 32'h0, 32'h7fff_ffff);
        add_request(OP_READ, 5'd3, 32'h0, 32'h0);
        add_request(OP_READ, 5'd4, 32'h0, 32'h0);
        add_request(OP_UPDATE, 5'd31, 32'hffff_ffff, 32'h0);
        add_request(OP_DELETE, 5'd3, 32'h0, 32'h0);
        add_request(OP_DELETE, 5'd0, 32'h0, 32'h0);
        add_request(OP_RSVD5, 5'd31, 32'hffff_ffff, 32'hffff_ffff);
        add_request(OP_RSVD6, 5'd0, 32'h0, 32'h0);
        add_request(OP_RSVD7, 5'd16, 32'h5555_5555, 32'haaaa_aaaa);
        add_request(OP_READ, 5'd0, 32'h0, 32'h0);
        add_request(OP_READ, 5'd1, 32'h0, 32'h0);
        add_request(OP_DELETE, 5'd16, 32'h0, 32'h0);

        // random: blocks that grow, drain or churn the array
        n = 0;
        for (blk = 0; n < RANDOM_ITEMS; blk++)
        begin
            case (blk == 0 ? 2 : $urandom_range(2))
                0:       ins_pct = 15;
                1:       ins_pct = 40;
                default: ins_pct = 70;
            endcase
            repeat (BLOCK_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 2)
                    op = OP_RSVD5 + 3'($urandom_range(2));
                else if (pick < ins_pct)
                    op = OP_INSERT;
                else
                    op = OP_DELETE + 3'($urandom_range(3));
                if ($urandom_range(99) < 15)
                    pos = 5'($urandom_range(31));
                else if (op == OP_INSERT)
                    pos = 5'($urandom_range(gen_count));
                else
                    pos = (gen_count == 0) ? 5'd0 : 5'($urandom_range(gen_count - 1));
                if (key_pool.size() != 0 && $urandom_range(99) < 70)
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
                else
                    key = pick_word();
                add_request(op, pos, pick_word(), key);
                n++;
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (n_accepted >= total_items / 3);
        send_idle = 64;
        recv_idle = 25;
        wait (n_accepted >= 2 * total_items / 3);
        send_idle = 0;
        recv_idle = 0;

        wait (n_accepted == total_items && result_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_errors == 0 && result_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/pae_pkg.sv
rtl/core/pae_ram.sv
rtl/core/positional_array_engine.sv
tb/positional_array_engine_test.sv
